// ===== design/mst_pkg.sv =====
// shared types and codes for the multi-slot timer table
package mst_pkg;

  // command codes of the input beat
  typedef enum logic [3:0] {
    CMD_POLL    = 4'd0,
    CMD_SET     = 4'd1,
    CMD_DELETE  = 4'd2,
    CMD_RESTART = 4'd3,
    CMD_ENABLE  = 4'd4,
    CMD_DISABLE = 4'd5,
    CMD_TOGGLE  = 4'd6,
    CMD_QENABLE = 4'd7,
    CMD_QCOUNT  = 4'd8
  } mst_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DRAIN_RD,
    ST_DRAIN_OUT
  } mst_state_t;

  typedef struct packed {
    logic [3:0]  command;
    logic [31:0] now_time;
    logic [3:0]  slot;
    logic [30:0] period;
    logic [15:0] run_limit;
    logic [15:0] user_tag;
  } mst_in_beat_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  out_slot;
    logic        fired;
    logic        removed;
    logic [15:0] tag_out;
    logic [4:0]  active_count;
    logic        last;
  } mst_out_beat_t;

  // access strobes towards the slot tables
  typedef struct packed {
    logic rd_en;
    logic time_we;
    logic prm_we;
  } mst_ram_ctl_t;

endpackage

// ===== design/mst_slot_ram.sv =====
// slot tables: fire time table and parameter table, one read and one write port each
module mst_slot_ram import mst_pkg::*; #(
  parameter int NUM_SLOTS  = 16,
  parameter int TIME_BITS  = 32,
  parameter int COUNT_BITS = 16,
  parameter int SLOT_W     = 4,
  parameter int PRM_W      = 79
) (
  input  logic                 clk,
  input  mst_ram_ctl_t         ctl,
  input  logic [SLOT_W-1:0]    rd_addr,
  input  logic [SLOT_W-1:0]    time_wr_addr,
  input  logic [TIME_BITS-1:0] time_wr_data,
  input  logic [SLOT_W-1:0]    prm_wr_addr,
  input  logic [PRM_W-1:0]     prm_wr_data,
  output logic [TIME_BITS-1:0] time_rd_data,
  output logic [PRM_W-1:0]     prm_rd_data
);

  logic [TIME_BITS-1:0] time_mem [NUM_SLOTS];
  logic [PRM_W-1:0]     prm_mem  [NUM_SLOTS];
  logic [TIME_BITS-1:0] time_rd_r;
  logic [PRM_W-1:0]     prm_rd_r;

  always_ff @(posedge clk) begin
    if (ctl.time_we) begin
      time_mem[time_wr_addr] <= time_wr_data;
    end
    if (ctl.rd_en) begin
      time_rd_r <= time_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.prm_we) begin
      prm_mem[prm_wr_addr] <= prm_wr_data;
    end
    if (ctl.rd_en) begin
      prm_rd_r <= prm_mem[rd_addr];
    end
  end

  assign time_rd_data = time_rd_r;
  assign prm_rd_data  = prm_rd_r;

endmodule

// ===== design/multi_slot_software_timer.sv =====
// multi-slot interval and timeout timer table, top level
//
//   beat   dir  payload          handshake
//   in_    in   mst_in_beat_t    in_valid / in_stall (stall driven here)
//   out_   out  mst_out_beat_t   out_valid / out_stall (stall driven by sink)
//
// a command other than poll is accepted, then executed into the output register
// a poll is accepted and walks every slot, then reads the tag of each firing slot from
//   the parameter table and sends its beat, or sends one empty beat when nothing fires
// the single read port of the slot tables sets the walk length
// reset clears occupied and enable bits, the active count and all control; the tables
//   themselves are not cleared, since a set writes every field before the slot is timed
// the result register holds while out_stall is high; the walk never pauses, and the drain
//   pauses only when a result is ready and the register is still full
module multi_slot_software_timer import mst_pkg::*; #(
  parameter int NUM_SLOTS  = 16,
  parameter int TIME_BITS  = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  mst_in_beat_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output mst_out_beat_t out_data
);

  localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W   = $clog2(NUM_SLOTS + 1);
  localparam int CMP_W   = (TIME_BITS > 31) ? TIME_BITS : 31;
  // parameter word: period | limit | run count | tag
  localparam int TAG_LSB = 0;
  localparam int RUN_LSB = 16;
  localparam int LIM_LSB = 16 + COUNT_BITS;
  localparam int PER_LSB = 16 + 2 * COUNT_BITS;
  localparam int PRM_W   = 31 + 2 * COUNT_BITS + 16;
  localparam logic [SLOT_W:0] SCAN_END = (SLOT_W + 1)'(NUM_SLOTS);

  // index of the single set bit of a one-hot vector
  function automatic logic [SLOT_W-1:0] oh_encode(input logic [NUM_SLOTS-1:0] oh);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (oh[i]) begin
        idx = idx | SLOT_W'(i);
      end
    end
    return idx;
  endfunction

  // slot index onto the 4-bit result field
  function automatic logic [3:0] slot4(input logic [SLOT_W-1:0] idx);
    logic [SLOT_W+3:0] w;
    w = {4'b0, idx};
    return w[3:0];
  endfunction

  // state and control
  mst_state_t          state_r, state_nxt;
  mst_in_beat_t        cmd_r, cmd_nxt;
  logic [NUM_SLOTS-1:0] occ_r, occ_nxt;
  logic [NUM_SLOTS-1:0] en_r, en_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [SLOT_W:0]     scan_cnt_r, scan_cnt_nxt;
  logic                proc_vld_r, proc_vld_nxt;
  logic [SLOT_W-1:0]   proc_idx_r, proc_idx_nxt;
  logic [NUM_SLOTS-1:0] fire_r, fire_nxt;
  logic [NUM_SLOTS-1:0] del_r, del_nxt;
  logic [SLOT_W-1:0]   drain_idx_r, drain_idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  mst_out_beat_t       out_data_r, out_data_nxt;

  logic          in_acc;
  logic          out_free;
  logic          out_load;
  mst_out_beat_t res;

  // table access
  mst_ram_ctl_t         ram_ctl;
  logic [SLOT_W-1:0]    rd_addr;
  logic [SLOT_W-1:0]    time_wr_addr;
  logic [TIME_BITS-1:0] time_wr_data;
  logic [SLOT_W-1:0]    prm_wr_addr;
  logic [PRM_W-1:0]     prm_wr_data;
  logic [TIME_BITS-1:0] time_rd_data;
  logic [PRM_W-1:0]     prm_rd_data;

  // fields of the held command, resized
  logic [SLOT_W+3:0]       s_wide;
  logic [SLOT_W-1:0]       s_idx;
  logic                    s_valid;
  logic [TIME_BITS+31:0]   now_wide;
  logic [TIME_BITS-1:0]    now_t;
  logic [COUNT_BITS+15:0]  lim_wide;
  logic [COUNT_BITS-1:0]   set_limit;

  // fields read back during the walk
  logic [30:0]             rd_period;
  logic [COUNT_BITS-1:0]   rd_limit;
  logic [COUNT_BITS-1:0]   rd_runs;
  logic [15:0]             rd_tag;
  logic [TIME_BITS-1:0]    diff;
  logic [CMP_W+TIME_BITS-1:0] diff_wide;
  logic [CMP_W+30:0]       per_cwide;
  logic [TIME_BITS+30:0]   per_twide;
  logic [TIME_BITS-1:0]    per_t;
  logic [TIME_BITS-1:0]    new_last;
  logic [COUNT_BITS-1:0]   runs_inc;
  logic                    due;
  logic                    lim_zero;
  logic                    under_lim;
  logic                    fire_now;
  logic                    del_now;
  logic                    scan_issue;

  // free slot search and drain pick
  logic [NUM_SLOTS-1:0] free_oh;
  logic                 free_found;
  logic [SLOT_W-1:0]    free_idx;
  logic [NUM_SLOTS-1:0] pend_oh;
  logic [SLOT_W-1:0]    pend_idx;
  logic [NUM_SLOTS-1:0] drain_oh;
  logic [CNT_W+4:0]     cnt_wide;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign s_wide   = {4'b0, cmd_r.slot} | {SLOT_W+4{1'b0}};
  assign s_idx    = s_wide[SLOT_W-1:0];
  assign s_valid  = s_wide < (SLOT_W + 4)'(NUM_SLOTS);
  assign now_wide = {{TIME_BITS{1'b0}}, cmd_r.now_time};
  assign now_t    = now_wide[TIME_BITS-1:0];
  assign lim_wide = {{COUNT_BITS{1'b0}}, cmd_r.run_limit};
  assign set_limit = lim_wide[COUNT_BITS-1:0];

  assign rd_period = prm_rd_data[PER_LSB +: 31];
  assign rd_limit  = prm_rd_data[LIM_LSB +: COUNT_BITS];
  assign rd_runs   = prm_rd_data[RUN_LSB +: COUNT_BITS];
  assign rd_tag    = prm_rd_data[TAG_LSB +: 16];

  // due test with wrapping elapsed time, then run limit bookkeeping
  assign diff      = now_t - time_rd_data;
  assign diff_wide = {{CMP_W{1'b0}}, diff};
  assign per_cwide = {{CMP_W{1'b0}}, rd_period};
  assign per_twide = {{TIME_BITS{1'b0}}, rd_period};
  assign per_t     = per_twide[TIME_BITS-1:0];
  assign new_last  = time_rd_data + per_t;
  assign due       = occ_r[proc_idx_r] &&
                     (diff_wide[CMP_W-1:0] >= per_cwide[CMP_W-1:0]);
  assign lim_zero  = (rd_limit == '0);
  assign under_lim = (rd_runs < rd_limit);
  assign runs_inc  = rd_runs + 1'b1;
  assign fire_now  = proc_vld_r && due && en_r[proc_idx_r] && (lim_zero || under_lim);
  assign del_now   = fire_now && !lim_zero && (runs_inc >= rd_limit);

  assign scan_issue = (state_r == ST_SCAN) && (scan_cnt_r != SCAN_END);

  // lowest free slot, lowest pending fire
  assign free_oh    = ~occ_r & (occ_r + 1'b1);
  assign free_found = ~&occ_r;
  assign free_idx   = oh_encode(free_oh);
  assign pend_oh    = fire_r & (~fire_r + 1'b1);
  assign pend_idx   = oh_encode(pend_oh);

  always_comb begin
    drain_oh = '0;
    drain_oh[drain_idx_r] = 1'b1;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_data.command == CMD_POLL) ? ST_SCAN : ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!scan_issue && !proc_vld_r) begin
          state_nxt = ST_DRAIN_RD;
        end
      end
      ST_DRAIN_RD: begin
        if (fire_r != '0) begin
          state_nxt = ST_DRAIN_OUT;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DRAIN_OUT: begin
        if (out_free) begin
          state_nxt = ((fire_r & ~drain_oh) == '0) ? ST_IDLE : ST_DRAIN_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath, table access and result
  always_comb begin
    cmd_nxt       = cmd_r;
    occ_nxt       = occ_r;
    en_nxt        = en_r;
    count_nxt     = count_r;
    scan_cnt_nxt  = scan_cnt_r;
    proc_vld_nxt  = 1'b0;
    proc_idx_nxt  = proc_idx_r;
    fire_nxt      = fire_r;
    del_nxt       = del_r;
    drain_idx_nxt = drain_idx_r;
    out_load      = 1'b0;
    res           = '0;
    ram_ctl       = '0;
    rd_addr       = scan_cnt_r[SLOT_W-1:0];
    time_wr_addr  = proc_idx_r;
    time_wr_data  = new_last;
    prm_wr_addr   = proc_idx_r;
    prm_wr_data   = {rd_period, rd_limit, runs_inc, rd_tag};

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt      = in_data;
          scan_cnt_nxt = '0;
          fire_nxt     = '0;
          del_nxt      = '0;
        end
      end

      ST_EXEC: begin
        if (out_free) begin
          out_load = 1'b1;
          res.last = 1'b1;
          unique case (cmd_r.command)
            CMD_SET: begin
              if (free_found) begin
                occ_nxt[free_idx] = 1'b1;
                en_nxt[free_idx]  = 1'b1;
                count_nxt         = count_r + 1'b1;
                ram_ctl.time_we   = 1'b1;
                time_wr_addr      = free_idx;
                time_wr_data      = now_t;
                ram_ctl.prm_we    = 1'b1;
                prm_wr_addr       = free_idx;
                prm_wr_data       = {cmd_r.period, set_limit, {COUNT_BITS{1'b0}},
                                     cmd_r.user_tag};
                res.ok            = 1'b1;
                res.out_slot      = slot4(free_idx);
              end
            end
            CMD_DELETE: begin
              if (s_valid && occ_r[s_idx]) begin
                occ_nxt[s_idx] = 1'b0;
                en_nxt[s_idx]  = 1'b0;
                count_nxt      = count_r - 1'b1;
              end
            end
            CMD_RESTART: begin
              if (s_valid) begin
                ram_ctl.time_we = 1'b1;
                time_wr_addr    = s_idx;
                time_wr_data    = now_t;
              end
            end
            CMD_ENABLE: begin
              if (s_valid) begin
                en_nxt[s_idx] = 1'b1;
              end
            end
            CMD_DISABLE: begin
              if (s_valid) begin
                en_nxt[s_idx] = 1'b0;
              end
            end
            CMD_TOGGLE: begin
              if (s_valid) begin
                en_nxt[s_idx] = !en_r[s_idx];
              end
            end
            CMD_QENABLE: begin
              res.ok = s_valid && en_r[s_idx];
            end
            default: begin
              // count query and unused codes: count only
            end
          endcase
        end
      end

      ST_SCAN: begin
        // read one slot, process the slot read in the previous cycle
        ram_ctl.rd_en = scan_issue;
        if (scan_issue) begin
          proc_vld_nxt = 1'b1;
          proc_idx_nxt = scan_cnt_r[SLOT_W-1:0];
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
        if (proc_vld_r && due) begin
          ram_ctl.time_we = 1'b1;
        end
        if (fire_now && !lim_zero) begin
          ram_ctl.prm_we = 1'b1;
        end
        if (proc_vld_r) begin
          fire_nxt[proc_idx_r] = fire_now;
          del_nxt[proc_idx_r]  = del_now;
        end
        if (del_now) begin
          occ_nxt[proc_idx_r] = 1'b0;
          en_nxt[proc_idx_r]  = 1'b0;
          count_nxt           = count_r - 1'b1;
        end
      end

      ST_DRAIN_RD: begin
        rd_addr = pend_idx;
        if (fire_r != '0) begin
          ram_ctl.rd_en = 1'b1;
          drain_idx_nxt = pend_idx;
        end else if (out_free) begin
          // nothing fired: one empty beat
          out_load = 1'b1;
          res.last = 1'b1;
        end
      end

      ST_DRAIN_OUT: begin
        if (out_free) begin
          out_load              = 1'b1;
          res.out_slot          = slot4(drain_idx_r);
          res.fired             = 1'b1;
          res.removed           = del_r[drain_idx_r];
          res.tag_out           = rd_tag;
          res.last              = ((fire_r & ~drain_oh) == '0);
          fire_nxt[drain_idx_r] = 1'b0;
        end
      end

      default: begin
      end
    endcase
  end

  // active count after the command goes with every beat
  assign cnt_wide = {5'b0, count_nxt};

  always_comb begin
    out_data_nxt              = res;
    out_data_nxt.active_count = cnt_wide[4:0];
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      en_r        <= '0;
      count_r     <= '0;
      scan_cnt_r  <= '0;
      proc_vld_r  <= 1'b0;
      fire_r      <= '0;
      del_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      en_r        <= en_nxt;
      count_r     <= count_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      proc_vld_r  <= proc_vld_nxt;
      fire_r      <= fire_nxt;
      del_r       <= del_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    proc_idx_r  <= proc_idx_nxt;
    drain_idx_r <= drain_idx_nxt;
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  mst_slot_ram #(
    .NUM_SLOTS  (NUM_SLOTS),
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS),
    .SLOT_W     (SLOT_W),
    .PRM_W      (PRM_W)
  ) u_slot_ram (
    .clk          (clk),
    .ctl          (ram_ctl),
    .rd_addr      (rd_addr),
    .time_wr_addr (time_wr_addr),
    .time_wr_data (time_wr_data),
    .prm_wr_addr  (prm_wr_addr),
    .prm_wr_data  (prm_wr_data),
    .time_rd_data (time_rd_data),
    .prm_rd_data  (prm_rd_data)
  );

endmodule

// ===== dv/multi_slot_software_timer_test.sv =====
// self-checking testbench for the multi-slot timer table: directed cases, full table, random traffic
module multi_slot_software_timer_test;
  import mst_pkg::*;

  localparam int NUM_SLOTS = 16;

  // command codes the block does not know, answered with zeros plus the count
  localparam logic [3:0] CMD_RSVD_FIRST = 4'd9;
  localparam logic [3:0] CMD_RSVD_LAST  = 4'd15;

  // chance in a hundred that a side idles for a while
  localparam int IDLE_PCT = 11;

  // a poll walks every slot, then gives one beat per firing slot, or one empty beat when nothing
  // fires, so this wait is ample margin
  localparam int DRAIN_CYCLES = 80;
  localparam int DRAIN_LIMIT  = 20000;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  mst_in_beat_t  in_data;
  logic          out_valid;
  logic          out_stall;
  mst_out_beat_t out_data;

  // set during the stretch where neither side idles
  bit          steady;
  int unsigned fail_count;

  // running millisecond clock for the random traffic
  logic [31:0] sim_ms;

  // shadow copy of the timer table, updated as each input beat is accepted
  logic [NUM_SLOTS-1:0] slot_used;
  logic [NUM_SLOTS-1:0] slot_on;
  logic [30:0]          slot_delay [NUM_SLOTS];
  logic [31:0]          slot_stamp [NUM_SLOTS];
  logic [15:0]          slot_cap   [NUM_SLOTS];
  logic [15:0]          slot_runs  [NUM_SLOTS];
  logic [15:0]          slot_label [NUM_SLOTS];
  logic [4:0]           live_slots;

  // result beats still owed by the block, oldest first
  mst_out_beat_t pending_results[$];

  multi_slot_software_timer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 10 unit clock period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow table
  // ---------------------------------------------------------------------------

  // freeing a slot clears its marks, its delay and its run count
  task automatic free_timer(input int idx);
    slot_used[idx]  = 1'b0;
    slot_on[idx]    = 1'b0;
    slot_delay[idx] = '0;
    slot_runs[idx]  = '0;
    if (live_slots != 0) live_slots = live_slots - 5'd1;
  endtask

  // apply one command to the shadow table and queue the beats it should produce
  task automatic timer_table_step(input mst_in_beat_t b);
    mst_out_beat_t        r;
    mst_out_beat_t        batch[$];
    logic [NUM_SLOTS-1:0] hit;
    logic [NUM_SLOTS-1:0] drop;
    logic [31:0]          elapsed;
    int                   s;
    int                   free_idx;

    r        = '0;
    s        = b.slot;
    hit      = '0;
    drop     = '0;
    free_idx = -1;

    case (b.command)
      CMD_POLL: begin
        // first pass decides who is due, advances stamps and counts runs
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_used[i]) begin
            elapsed = b.now_time - slot_stamp[i];
            if (elapsed >= {1'b0, slot_delay[i]}) begin
              // a due slot always moves on, enabled or not
              slot_stamp[i] = slot_stamp[i] + {1'b0, slot_delay[i]};
              if (slot_on[i]) begin
                if (slot_cap[i] == 0) begin
                  hit[i] = 1'b1;
                end else if (slot_runs[i] < slot_cap[i]) begin
                  hit[i]       = 1'b1;
                  slot_runs[i] = slot_runs[i] + 16'd1;
                  if (slot_runs[i] >= slot_cap[i]) drop[i] = 1'b1;
                end
              end
            end
          end
        end
        // second pass reports fires in slot order and frees exhausted slots
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (hit[i]) begin
            r          = '0;
            r.out_slot = 4'(i);
            r.fired    = 1'b1;
            r.removed  = drop[i];
            r.tag_out  = slot_label[i];
            batch.push_back(r);
            if (drop[i]) free_timer(i);
          end
        end
        if (batch.size() == 0) batch.push_back('0);
      end
      CMD_SET: begin
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
          if (!slot_used[i]) free_idx = i;
        end
        // a full table leaves everything alone and reports ok = 0
        if (free_idx >= 0) begin
          slot_used[free_idx]  = 1'b1;
          slot_on[free_idx]    = 1'b1;
          slot_delay[free_idx] = b.period;
          slot_stamp[free_idx] = b.now_time;
          slot_cap[free_idx]   = b.run_limit;
          slot_runs[free_idx]  = '0;
          slot_label[free_idx] = b.user_tag;
          live_slots           = live_slots + 5'd1;
          r.ok                 = 1'b1;
          r.out_slot           = 4'(free_idx);
        end
        batch.push_back(r);
      end
      CMD_DELETE: begin
        if (slot_used[s]) free_timer(s);
        batch.push_back(r);
      end
      CMD_RESTART: begin
        // also written on a free slot; a later set overwrites it
        slot_stamp[s] = b.now_time;
        batch.push_back(r);
      end
      CMD_ENABLE: begin
        slot_on[s] = 1'b1;
        batch.push_back(r);
      end
      CMD_DISABLE: begin
        slot_on[s] = 1'b0;
        batch.push_back(r);
      end
      CMD_TOGGLE: begin
        slot_on[s] = !slot_on[s];
        batch.push_back(r);
      end
      CMD_QENABLE: begin
        r.ok = slot_on[s];
        batch.push_back(r);
      end
      default: begin
        // count query and unknown codes: zeros plus the count
        batch.push_back(r);
      end
    endcase

    // count is the one after the whole command, last marks the final beat
    foreach (batch[k]) begin
      batch[k].active_count = live_slots;
      batch[k].last         = (k == batch.size() - 1);
      pending_results.push_back(batch[k]);
    end
  endtask

  // every accepted input beat goes through the shadow table
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) timer_table_step(in_data);
  end

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    mst_out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: result beat with nothing expected, got %h", $time, out_data);
      end else begin
        want = pending_results.pop_front();
        check_field("ok",           want.ok,           out_data.ok);
        check_field("out_slot",     want.out_slot,     out_data.out_slot);
        check_field("fired",        want.fired,        out_data.fired);
        check_field("removed",      want.removed,      out_data.removed);
        check_field("tag_out",      want.tag_out,      out_data.tag_out);
        check_field("active_count", want.active_count, out_data.active_count);
        check_field("last",         want.last,         out_data.last);
      end
    end
  end

  // sink back-pressure, random except during the steady stretch
  always @(negedge clk) begin
    out_stall <= rst_n && !steady && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic mst_in_beat_t make_beat(input logic [3:0] cmd, input logic [31:0] now,
                                             input logic [3:0] sl, input logic [30:0] per,
                                             input logic [15:0] lim, input logic [15:0] tg);
    mst_in_beat_t b;
    b.command   = cmd;
    b.now_time  = now;
    b.slot      = sl;
    b.period    = per;
    b.run_limit = lim;
    b.user_tag  = tg;
    return b;
  endfunction

  // present one beat at a falling edge, maybe after a gap, and hold it until taken
  task automatic send_beat(input mst_in_beat_t b);
    int unsigned gap;
    @(negedge clk);
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // empty table, field extremes, every command and the corner cases one at a time
  task automatic test_directed_cases();
    logic [31:0] t0;
    t0 = 32'hFFFF_FFF0;
    // nothing occupied yet: poll, count and flag queries
    send_beat(make_beat(CMD_POLL,    32'h0, 4'd0,  31'd0, 16'd0, 16'd0));
    send_beat(make_beat(CMD_QCOUNT,  32'h0, 4'd0,  31'd0, 16'd0, 16'd0));
    send_beat(make_beat(CMD_QENABLE, 32'h0, 4'd15, 31'd0, 16'd0, 16'd0));
    // slot 0: zero delay so due at every poll, runs forever, all-ones tag
    send_beat(make_beat(CMD_SET, t0, 4'd0, 31'd0, 16'd0, 16'hFFFF));
    // slot 1: longest delay and longest run limit, never due here
    send_beat(make_beat(CMD_SET, t0, 4'd0, 31'h7FFF_FFFF, 16'hFFFF, 16'h0000));
    // slot 2: one-shot
    send_beat(make_beat(CMD_SET, t0, 4'd0, 31'h20, 16'd1, 16'hA5A5));
    // slot 3: two runs, parked disabled for the first poll
    send_beat(make_beat(CMD_SET,     t0,    4'd0, 31'h10, 16'd2, 16'h5A5A));
    send_beat(make_beat(CMD_DISABLE, 32'h0, 4'd3, 31'd0,  16'd0, 16'd0));
    send_beat(make_beat(CMD_QENABLE, 32'h0, 4'd3, 31'd0,  16'd0, 16'd0));
    send_beat(make_beat(CMD_QENABLE, 32'h0, 4'd0, 31'd0,  16'd0, 16'd0));
    // time wraps through zero: slot 0 fires, slot 2 fires and goes, slot 3 due but quiet
    send_beat(make_beat(CMD_POLL,   32'h10, 4'd0, 31'd0, 16'd0, 16'd0));
    send_beat(make_beat(CMD_TOGGLE, 32'h0,  4'd3, 31'd0, 16'd0, 16'd0));
    // slot 0 again and the first run of slot 3
    send_beat(make_beat(CMD_POLL,   32'h20, 4'd0, 31'd0, 16'd0, 16'd0));
    // delete a live slot, then the same slot once it is free
    send_beat(make_beat(CMD_DELETE, 32'h0, 4'd0, 31'd0, 16'd0, 16'd0));
    send_beat(make_beat(CMD_DELETE, 32'h0, 4'd0, 31'd0, 16'd0, 16'd0));
    // enable bit of a free slot is still written and reads back
    send_beat(make_beat(CMD_ENABLE,  32'h0, 4'd15, 31'd0, 16'd0, 16'd0));
    send_beat(make_beat(CMD_QENABLE, 32'h0, 4'd15, 31'd0, 16'd0, 16'd0));
    // restart pushes slot 3 out: first poll sees nothing due, second is its last run
    send_beat(make_beat(CMD_RESTART, 32'h100, 4'd3, 31'd0, 16'd0, 16'd0));
    send_beat(make_beat(CMD_POLL,    32'h105, 4'd0, 31'd0, 16'd0, 16'd0));
    send_beat(make_beat(CMD_POLL,    32'h110, 4'd0, 31'd0, 16'd0, 16'd0));
    // unknown codes at both ends of the unused range
    send_beat(make_beat(CMD_RSVD_FIRST, 32'hFFFF_FFFF, 4'hF, 31'h7FFF_FFFF, 16'hFFFF, 16'hFFFF));
    send_beat(make_beat(CMD_RSVD_LAST,  32'hFFFF_FFFF, 4'hF, 31'h7FFF_FFFF, 16'hFFFF, 16'hFFFF));
    // leave the table empty for the fill test
    send_beat(make_beat(CMD_DELETE, 32'h0, 4'd1, 31'd0, 16'd0, 16'd0));
  endtask

  // fill every slot, try one more set, then make all of them due in one poll
  task automatic test_table_full();
    logic [31:0] base;
    base = $urandom;
    for (int i = 0; i <= NUM_SLOTS; i++) begin
      send_beat(make_beat(CMD_SET, base, 4'(i), 31'($urandom_range(0, 3)),
                          16'($urandom_range(0, 2)), 16'($urandom)));
    end
    send_beat(make_beat(CMD_QCOUNT, base, 4'd0, 31'd0, 16'd0, 16'd0));
    // sixteen fires from a single poll, one-shot slots freed on the way
    send_beat(make_beat(CMD_POLL, base + 32'd8,  4'd0, 31'd0, 16'd0, 16'd0));
    send_beat(make_beat(CMD_POLL, base + 32'd16, 4'd0, 31'd0, 16'd0, 16'd0));
  endtask

  // mostly sets and polls on a running clock with short delays, so slots keep firing
  task automatic test_random_traffic(input int n_items);
    mst_in_beat_t b;
    int unsigned  pick;
    for (int k = 0; k < n_items; k++) begin
      // a long stretch in the middle runs with no idling on either side
      steady = (k >= n_items / 3) && (k < n_items / 3 + 100);
      // fields a command does not use still carry random noise
      b.now_time  = $urandom;
      b.slot      = 4'($urandom);
      b.period    = 31'($urandom);
      b.run_limit = 16'($urandom);
      b.user_tag  = 16'($urandom);
      pick = $urandom_range(0, 99);
      // now and then the clock leaps, forcing catch-up and wrapped differences
      if (pick < 3) sim_ms = sim_ms + $urandom;
      if (pick < 32) begin
        b.command  = CMD_POLL;
        sim_ms     = sim_ms + $urandom_range(0, 24);
        b.now_time = sim_ms;
      end else if (pick < 56) begin
        b.command  = CMD_SET;
        b.now_time = sim_ms;
        if ($urandom_range(0, 9) != 0) b.period = 31'($urandom_range(0, 60));
        pick = $urandom_range(0, 9);
        if (pick < 3) b.run_limit = '0;
        else if (pick < 8) b.run_limit = 16'($urandom_range(1, 4));
      end else if (pick < 64) begin
        b.command = CMD_DELETE;
      end else if (pick < 69) begin
        b.command  = CMD_RESTART;
        b.now_time = sim_ms;
      end else if (pick < 75) begin
        b.command = CMD_ENABLE;
      end else if (pick < 81) begin
        b.command = CMD_DISABLE;
      end else if (pick < 87) begin
        b.command = CMD_TOGGLE;
      end else if (pick < 94) begin
        b.command = CMD_QENABLE;
      end else if (pick < 98) begin
        b.command = CMD_QCOUNT;
      end else begin
        b.command = 4'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
      end
      // low slots fill first, so aim most per-slot commands there
      if (b.command != CMD_POLL && b.command != CMD_SET && $urandom_range(0, 3) != 0)
        b.slot = 4'($urandom_range(0, 5));
      send_beat(b);
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin : main_seq
    int waited;
    in_valid   = 1'b0;
    in_data    = '0;
    out_stall  = 1'b0;
    rst_n      = 1'b0;
    steady     = 1'b0;
    fail_count = 0;
    sim_ms     = $urandom;
    // shadow table starts at its reset state
    slot_used  = '0;
    slot_on    = '0;
    live_slots = '0;
    for (int i = 0; i < NUM_SLOTS; i++) slot_runs[i] = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_table_full();
    test_random_traffic(390);

    @(negedge clk);
    in_valid <= 1'b0;

    // let the outstanding beats drain, then watch a little longer for strays
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      fail_count++;
      $display("%0t: %0d expected result beats never arrived", $time,
               pending_results.size());
    end

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

endmodule
